### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Expects clk_i and rst_ni in the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tkdlp_pkg.sv
// Types and constants of the two-key debounce / long-press core.
// No dependencies.
`timescale 1ns / 1ps

package tkdlp_pkg;

  localparam int unsigned PortW    = 8;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned HeldW    = 32;
  localparam int unsigned BitSelW  = 3;
  localparam int unsigned ThrW     = 42;  // ms limit times 1000 in us
  localparam int unsigned KeyCount = 2;

  localparam logic [HeldW-1:0]   LongPressRst = 32'd1000;
  localparam logic [BitSelW-1:0] FirstBitRst  = 3'd0;
  localparam logic [BitSelW-1:0] SecondBitRst = 3'd1;
  localparam logic [ThrW-1:0]    ThrRst       = 42'd1000000;

  // dt / 1000 == (dt / 8) / 125, done as two reciprocal steps.
  // RecipHi: ceil(2^30 / 125) for a 23-bit dividend.
  // RecipLo: ceil(2^36 / 125) for a 29-bit dividend.
  localparam logic [23:0] RecipHi = 24'd8589935;
  localparam logic [29:0] RecipLo = 30'd549755814;
  localparam logic [6:0]  Div125  = 7'd125;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LONG    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_FIRST_BIT  = 2'd1,
    REG_SECOND_BIT = 2'd2
  } reg_e;

  typedef struct packed {
    logic             valid;
    logic             key;
    kind_e            kind;
    logic [TimeW-1:0] dt;
  } event_t;

endpackage

### rtl/core/two_key_debounce_long_press_core.sv
// Two-key debouncer with long-press events. Depends on tkdlp_pkg, assert_macros.svh.
// Path: an issued event passes registers a, b, c and out before it drives tvalid.
// Throughput: a poll holds the input register until its last event is issued,
//   so a poll with two events holds it longer than one with zero or one; set by
//   the single output stream that moves one event beat per cycle while m_axis_tready does not stall it.
// Reset: rst_ni async active low; clears key state, valids, registers to defaults.
`timescale 1ns / 1ps

module two_key_debounce_long_press_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream; tdata: port_sample [7:0], now_us [55:8]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [tkdlp_pkg::PortW+tkdlp_pkg::TimeW-1:0] s_axis_tdata,
  // output stream; tdata: held_ms [31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [tkdlp_pkg::HeldW-1:0] m_axis_tdata,
  // tuser: key_index [0], event_kind [2:1]; tlast: last_event
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TW = tkdlp_pkg::TimeW;
  localparam int unsigned NK = tkdlp_pkg::KeyCount;

  // ------------------------------------------------------------------
  // Registers. The long-press limit is also kept in microseconds
  // (max(limit,1) * 1000) so the per-poll test is a plain compare:
  // floor(dt/1000) >= L  <=>  dt >= 1000*L.
  // ------------------------------------------------------------------
  logic [tkdlp_pkg::HeldW-1:0]   long_press_q;
  logic [tkdlp_pkg::BitSelW-1:0] first_bit_q;
  logic [tkdlp_pkg::BitSelW-1:0] second_bit_q;
  logic [tkdlp_pkg::ThrW-1:0]    thr_q;
  logic [tkdlp_pkg::ThrW-1:0]    thr_wr;
  logic [31:0]                   lim_wr;
  logic                          cfg_we;
  tkdlp_pkg::reg_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = tkdlp_pkg::reg_e'(paddr[3:2]);
  assign lim_wr  = (pwdata == 32'd0) ? 32'd1 : pwdata;
  // x*1000 = x*1024 - x*16 - x*8
  assign thr_wr  = {lim_wr, 10'b0} - {6'b0, lim_wr, 4'b0} - {7'b0, lim_wr, 3'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= tkdlp_pkg::LongPressRst;
      first_bit_q  <= tkdlp_pkg::FirstBitRst;
      second_bit_q <= tkdlp_pkg::SecondBitRst;
      thr_q        <= tkdlp_pkg::ThrRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tkdlp_pkg::REG_LONG_PRESS: begin
          long_press_q <= pwdata;
          thr_q        <= thr_wr;
        end
        tkdlp_pkg::REG_FIRST_BIT:  first_bit_q  <= pwdata[2:0];
        tkdlp_pkg::REG_SECOND_BIT: second_bit_q <= pwdata[2:0];
        default: ;  // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tkdlp_pkg::REG_LONG_PRESS: prdata = long_press_q;
      tkdlp_pkg::REG_FIRST_BIT:  prdata = {29'b0, first_bit_q};
      tkdlp_pkg::REG_SECOND_BIT: prdata = {29'b0, second_bit_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // Input register: holds a poll until all its events left for the
  // divider pipeline. State commits when the poll retires.
  // ------------------------------------------------------------------
  logic                        in_valid_q;
  logic [tkdlp_pkg::PortW-1:0] in_port_q;
  logic [TW-1:0]               in_now_q;
  logic                        s_fire;
  logic                        retire;
  logic                        done0_q;  // first key's event already sent

  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = !in_valid_q || retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (retire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_port_q <= s_axis_tdata[tkdlp_pkg::PortW-1:0];
      in_now_q  <= s_axis_tdata[tkdlp_pkg::PortW +: TW];
    end
  end

  // ------------------------------------------------------------------
  // Per-key debounce: one subtract and one compare per key.
  // ------------------------------------------------------------------
  logic [NK-1:0]   prev_q, stable_q, long_rep_q;
  logic [TW-1:0]   press_time_q [NK];
  logic [tkdlp_pkg::BitSelW-1:0] key_bit [NK];
  logic [NK-1:0]   raw, take, press, rel, long_hit, new_stable;
  logic [TW-1:0]   dt [NK];
  tkdlp_pkg::event_t ev [NK];

  assign key_bit[0] = first_bit_q;
  assign key_bit[1] = second_bit_q;

  always_comb begin
    for (int k = 0; k < NK; k++) begin
      raw[k]        = ~in_port_q[key_bit[k]];
      take[k]       = (raw[k] != stable_q[k]) && (raw[k] == prev_q[k]);
      press[k]      = take[k] & raw[k];
      rel[k]        = take[k] & ~raw[k];
      new_stable[k] = take[k] ? raw[k] : stable_q[k];
      dt[k]         = in_now_q - press_time_q[k];
      // a fresh press has dt 0 and the limit is at least 1000 us
      long_hit[k]   = new_stable[k] && !press[k] && !long_rep_q[k] &&
                      (dt[k] >= {{(TW-tkdlp_pkg::ThrW){1'b0}}, thr_q});
      ev[k].valid   = press[k] | rel[k] | long_hit[k];
      ev[k].key     = 1'(k);
      if (press[k]) begin
        ev[k].kind = tkdlp_pkg::KIND_PRESS;
      end else if (rel[k]) begin
        ev[k].kind = tkdlp_pkg::KIND_RELEASE;
      end else begin
        ev[k].kind = tkdlp_pkg::KIND_LONG;
      end
      ev[k].dt      = press[k] ? '0 : dt[k];
    end
  end

  // ------------------------------------------------------------------
  // Event issue: first key then second, one beat per cycle while the output does not stall.
  // ------------------------------------------------------------------
  logic              adv;       // whole divider pipeline moves
  logic              pend0, pend_any, emit, emit_last;
  tkdlp_pkg::event_t emit_ev;
  logic              out_valid_q;

  assign adv       = !out_valid_q || m_axis_tready;
  assign pend0     = ev[0].valid && !done0_q;
  assign pend_any  = pend0 || ev[1].valid;
  assign emit      = in_valid_q && pend_any && adv;
  assign emit_ev   = pend0 ? ev[0] : ev[1];
  assign emit_last = pend0 ? !ev[1].valid : 1'b1;
  assign retire    = in_valid_q && (!pend_any || (adv && emit_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done0_q <= 1'b0;
    end else if (retire) begin
      done0_q <= 1'b0;
    end else if (emit && pend0) begin
      done0_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      stable_q   <= '0;
      long_rep_q <= '0;
      for (int k = 0; k < NK; k++) begin
        press_time_q[k] <= '0;
      end
    end else if (retire) begin
      prev_q   <= raw;
      stable_q <= new_stable;
      for (int k = 0; k < NK; k++) begin
        if (press[k]) begin
          press_time_q[k] <= in_now_q;
          long_rep_q[k]   <= 1'b0;
        end else if (long_hit[k]) begin
          long_rep_q[k]   <= 1'b1;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Divide-by-1000 pipeline. dt/8 = hi*2^22 + lo; q1 = hi/125,
  // r1 = hi%125, q2 = (r1*2^22 + lo)/125; result {q1, q2}, low 32 bits.
  // Stall is global: everything holds while the output beat waits.
  // ------------------------------------------------------------------
  logic                   a_valid_q, a_key_q, a_last_q;
  tkdlp_pkg::kind_e       a_kind_q;
  logic [TW-1:0]          a_dt_q;

  logic                   b_valid_q, b_key_q, b_last_q;
  tkdlp_pkg::kind_e       b_kind_q;
  logic [16:0]            b_q1_q;
  logic [22:0]            b_hi_q;
  logic [21:0]            b_lo_q;
  logic [46:0]            prod1;

  logic                   c_valid_q, c_key_q, c_last_q;
  tkdlp_pkg::kind_e       c_kind_q;
  logic [9:0]             c_q1_q;
  logic [28:0]            c_y_q;
  logic [22:0]            q1x125, r1;

  logic                   out_key_q, out_last_q;
  tkdlp_pkg::kind_e       out_kind_q;
  logic [tkdlp_pkg::HeldW-1:0] out_held_q;
  logic [58:0]            prod2;

  assign prod1  = {24'b0, a_dt_q[47:25]} * {23'b0, tkdlp_pkg::RecipHi};
  assign q1x125 = {6'b0, b_q1_q} * {16'b0, tkdlp_pkg::Div125};
  assign r1     = b_hi_q - q1x125;
  assign prod2  = {30'b0, c_y_q} * {29'b0, tkdlp_pkg::RecipLo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= emit;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (emit) begin
        a_key_q  <= emit_ev.key;
        a_kind_q <= emit_ev.kind;
        a_dt_q   <= emit_ev.dt;
        a_last_q <= emit_last;
      end
      b_key_q    <= a_key_q;
      b_kind_q   <= a_kind_q;
      b_last_q   <= a_last_q;
      b_q1_q     <= prod1[46:30];
      b_hi_q     <= a_dt_q[47:25];
      b_lo_q     <= a_dt_q[24:3];
      c_key_q    <= b_key_q;
      c_kind_q   <= b_kind_q;
      c_last_q   <= b_last_q;
      c_q1_q     <= b_q1_q[9:0];
      c_y_q      <= {r1[6:0], b_lo_q};
      out_key_q  <= c_key_q;
      out_kind_q <= c_kind_q;
      out_last_q <= c_last_q;
      out_held_q <= {c_q1_q, prod2[57:36]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_held_q;
  assign m_axis_tuser  = {out_kind_q, out_key_q};
  assign m_axis_tlast  = out_last_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_done_needs_poll, done0_q |-> in_valid_q, "first-key mark without a poll")
  `ASSERT_NEXT(a_poll_holds, in_valid_q && !retire, in_valid_q && $stable(in_now_q), "poll lost")
  `ASSERT_ALWAYS(a_press_zero, a_valid_q && (a_kind_q == tkdlp_pkg::KIND_PRESS) |-> (a_dt_q == '0), "press dt")
  `ASSERT_ALWAYS(a_rem_range, c_valid_q |-> (c_y_q[28:22] < tkdlp_pkg::Div125), "bad remainder")

endmodule
